// File: rtl/array_list_engine_macros.svh
// assertion macros for the array list engine checker
`ifndef ARRAY_LIST_ENGINE_MACROS_SVH
`define ARRAY_LIST_ENGINE_MACROS_SVH

// same-cycle implication, quiet during reset
`define ALE_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("array list engine check failed");

// next-cycle implication, quiet during reset
`define ALE_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("array list engine check failed");

// state seen in the cycle after reset is applied
`define ALE_ASSERT_RESET(name, cons) \
    name: assert property (@(posedge i_clk) !i_rst_n |=> (cons)) \
        else $error("array list engine reset check failed");

`endif

// File: rtl/ale_pkg.sv
package ale_pkg;

    // default sizing
    localparam int DEF_CAPACITY   = 256;
    localparam int DEF_WORD_WIDTH = 32;

    // fixed field widths
    localparam int ACT_W  = 4;
    localparam int IDX_W  = 8;
    localparam int SPAN_W = 9;
    localparam int DATA_W = 32;
    localparam int LEN_W  = 9;
    localparam int STAT_W = 2;

    // action codes
    localparam logic [ACT_W-1:0] ACT_APPEND       = 4'd0;
    localparam logic [ACT_W-1:0] ACT_POP          = 4'd1;
    localparam logic [ACT_W-1:0] ACT_GET          = 4'd2;
    localparam logic [ACT_W-1:0] ACT_REPLACE      = 4'd3;
    localparam logic [ACT_W-1:0] ACT_REMOVE_AT    = 4'd4;
    localparam logic [ACT_W-1:0] ACT_REMOVE_RANGE = 4'd5;
    localparam logic [ACT_W-1:0] ACT_CONTAINS     = 4'd6;
    localparam logic [ACT_W-1:0] ACT_REMOVE_FIRST = 4'd7;
    localparam logic [ACT_W-1:0] ACT_REMOVE_ALL   = 4'd8;
    localparam logic [ACT_W-1:0] ACT_REVERSE      = 4'd9;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

    // request and result payloads
    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [IDX_W-1:0]  index;
        logic [SPAN_W-1:0] span;
        logic [DATA_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [DATA_W-1:0] data_out;
        logic              hit;
        logic [LEN_W-1:0]  removed_count;
        logic [LEN_W-1:0]  length;
        logic [STAT_W-1:0] status;
    } t_rsp;

    // result fields other than the data word, from the sequencer
    typedef struct packed {
        logic              hit;
        logic [LEN_W-1:0]  removed_count;
        logic [LEN_W-1:0]  length;
        logic [STAT_W-1:0] status;
    } t_rsp_meta;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_SCAN,
        S_REV_B,
        S_REV_C,
        S_REV_D
    } t_state;

    // what a scan does with each word it reads
    typedef enum logic [1:0] {
        M_SEARCH,
        M_COPY,
        M_DROP
    } t_mode;

endpackage

// File: rtl/array_list_engine.sv
// channel   | handshake        | payload
// ----------+------------------+-----------------------
// request   | start, busy      | i_req  (ale_pkg::t_req)
// result    | o_done (strobe)  | o_rsp  (ale_pkg::t_rsp)
//
// append, unknown actions and refused requests: result in the cycle after the request
// pop, get, replace: a read through S_FETCH, then the result; remove_at adds a walk of the words above the index
// removals, searches and reverse walk the stored words, bound by
// the single read port of the entry ram giving one word per cycle
// synchronous reset clears the sequencer state, length and result strobe; the entry ram is not swept
// new request in any cycle busy is low, result cycle included; receiver cannot stall
module array_list_engine #(
    parameter int CAPACITY   = ale_pkg::DEF_CAPACITY,
    parameter int WORD_WIDTH = ale_pkg::DEF_WORD_WIDTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  ale_pkg::t_req i_req,
    output logic          busy,
    output logic          o_done,
    output ale_pkg::t_rsp o_rsp
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int DW = ale_pkg::DATA_W;

    logic [WORD_WIDTH-1:0] word_in;
    logic [WORD_WIDTH-1:0] word_out;
    ale_pkg::t_rsp_meta    meta;
    logic [AW-1:0]         rd_addr;
    logic [WORD_WIDTH-1:0] rd_data;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [WORD_WIDTH-1:0] wr_data;

    // request word cut or widened to the stored width
    assign word_in = WORD_WIDTH'(i_req.value);

    ale_ctrl #(
        .CAPACITY   (CAPACITY),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_req     (i_req),
        .i_word    (word_in),
        .o_busy    (busy),
        .o_done    (o_done),
        .o_word    (word_out),
        .o_meta    (meta),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data)
    );

    ale_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // result assembly
    always_comb begin
        o_rsp.data_out      = DW'(word_out);
        o_rsp.hit           = meta.hit;
        o_rsp.removed_count = meta.removed_count;
        o_rsp.length        = meta.length;
        o_rsp.status        = meta.status;
    end

endmodule

// File: rtl/ale_ram.sv
module ale_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/ale_ctrl.sv
module ale_ctrl #(
    parameter int CAPACITY   = ale_pkg::DEF_CAPACITY,
    parameter int WORD_WIDTH = ale_pkg::DEF_WORD_WIDTH,
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  ale_pkg::t_req         i_req,
    input  logic [WORD_WIDTH-1:0] i_word,
    output logic                  o_busy,
    output logic                  o_done,
    output logic [WORD_WIDTH-1:0] o_word,
    output ale_pkg::t_rsp_meta    o_meta,
    output logic [AW-1:0]         o_rd_addr,
    input  logic [WORD_WIDTH-1:0] i_rd_data,
    output logic                  o_wr_en,
    output logic [AW-1:0]         o_wr_addr,
    output logic [WORD_WIDTH-1:0] o_wr_data
);

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int EW    = (CW > 10) ? CW : 10;
    localparam int LEN_W = ale_pkg::LEN_W;

    ale_pkg::t_state r_state, n_state;
    ale_pkg::t_mode  r_mode, n_mode;

    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_rd, n_rd;
    logic [CW-1:0]         r_wr, n_wr;
    logic [CW-1:0]         r_paddr, n_paddr;
    logic                  r_pend, n_pend;
    logic                  r_done, n_done;
    logic [3:0]            r_act, n_act;
    logic [WORD_WIDTH-1:0] r_word, n_word;
    logic [WORD_WIDTH-1:0] r_data, n_data;
    logic [WORD_WIDTH-1:0] r_hold, n_hold;
    logic                  r_hit, n_hit;
    logic [CW-1:0]         r_removed, n_removed;
    logic [1:0]            r_status, n_status;
    logic [AW-1:0]         r_lo, n_lo;
    logic [AW-1:0]         r_hi, n_hi;

    logic [CW-1:0] cnt_m1;
    logic [EW-1:0] range_end;
    logic          match;
    logic          issue_ok;

    assign cnt_m1    = r_count - 1'b1;
    assign range_end = EW'(i_req.index) + EW'(i_req.span);
    assign match     = (i_rd_data == r_word);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ale_pkg::S_IDLE;
            r_mode  <= ale_pkg::M_SEARCH;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_done  <= n_done;
        end
    end

    // working and result registers
    always_ff @(posedge i_clk) begin
        r_rd      <= n_rd;
        r_wr      <= n_wr;
        r_paddr   <= n_paddr;
        r_act     <= n_act;
        r_word    <= n_word;
        r_data    <= n_data;
        r_hold    <= n_hold;
        r_hit     <= n_hit;
        r_removed <= n_removed;
        r_status  <= n_status;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_count   = r_count;
        n_rd      = r_rd;
        n_wr      = r_wr;
        n_paddr   = r_paddr;
        n_pend    = r_pend;
        n_done    = 1'b0;
        n_act     = r_act;
        n_word    = r_word;
        n_data    = r_data;
        n_hold    = r_hold;
        n_hit     = r_hit;
        n_removed = r_removed;
        n_status  = r_status;
        n_lo      = r_lo;
        n_hi      = r_hi;
        o_rd_addr = '0;
        o_wr_en   = 1'b0;
        o_wr_addr = '0;
        o_wr_data = i_rd_data;
        issue_ok  = 1'b1;

        unique case (r_state)
            ale_pkg::S_IDLE: begin
                if (i_start) begin
                    n_act     = i_req.action;
                    n_word    = i_word;
                    n_data    = '0;
                    n_hit     = 1'b0;
                    n_removed = '0;
                    n_status  = ale_pkg::ST_OK;
                    n_pend    = 1'b0;
                    n_wr      = CW'(i_req.index);
                    unique case (i_req.action)
                        ale_pkg::ACT_APPEND: begin
                            n_done = 1'b1;
                            if (r_count >= CW'(CAPACITY)) begin
                                n_status = ale_pkg::ST_FULL;
                            end else begin
                                o_wr_en   = 1'b1;
                                o_wr_addr = r_count[AW-1:0];
                                o_wr_data = i_word;
                                n_count   = r_count + 1'b1;
                            end
                        end
                        ale_pkg::ACT_POP: begin
                            if (r_count == '0) begin
                                n_status = ale_pkg::ST_EMPTY;
                                n_done   = 1'b1;
                            end else begin
                                n_count   = cnt_m1;
                                o_rd_addr = cnt_m1[AW-1:0];
                                n_state   = ale_pkg::S_FETCH;
                            end
                        end
                        ale_pkg::ACT_GET, ale_pkg::ACT_REPLACE,
                        ale_pkg::ACT_REMOVE_AT: begin
                            if (EW'(i_req.index) >= EW'(r_count)) begin
                                n_status = ale_pkg::ST_RANGE;
                                n_done   = 1'b1;
                            end else begin
                                o_rd_addr = AW'(i_req.index);
                                n_state   = ale_pkg::S_FETCH;
                            end
                        end
                        ale_pkg::ACT_REMOVE_RANGE: begin
                            if (range_end > EW'(r_count)) begin
                                n_status = ale_pkg::ST_RANGE;
                                n_done   = 1'b1;
                            end else begin
                                n_mode  = ale_pkg::M_COPY;
                                n_rd    = CW'(range_end);
                                n_state = ale_pkg::S_SCAN;
                            end
                        end
                        ale_pkg::ACT_CONTAINS, ale_pkg::ACT_REMOVE_FIRST: begin
                            n_mode  = ale_pkg::M_SEARCH;
                            n_rd    = '0;
                            n_state = ale_pkg::S_SCAN;
                        end
                        ale_pkg::ACT_REMOVE_ALL: begin
                            n_mode  = ale_pkg::M_DROP;
                            n_rd    = '0;
                            n_wr    = '0;
                            n_state = ale_pkg::S_SCAN;
                        end
                        ale_pkg::ACT_REVERSE: begin
                            if (r_count < CW'(2)) begin
                                n_done = 1'b1;
                            end else begin
                                // first word of the lowest pair is read now
                                n_lo      = '0;
                                n_hi      = cnt_m1[AW-1:0];
                                o_rd_addr = '0;
                                n_state   = ale_pkg::S_REV_B;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end

            // single word read has landed
            ale_pkg::S_FETCH: begin
                n_data = i_rd_data;
                unique case (r_act)
                    ale_pkg::ACT_REPLACE: begin
                        o_wr_en   = 1'b1;
                        o_wr_addr = r_wr[AW-1:0];
                        o_wr_data = r_word;
                        n_done    = 1'b1;
                        n_state   = ale_pkg::S_IDLE;
                    end
                    ale_pkg::ACT_REMOVE_AT: begin
                        n_mode  = ale_pkg::M_COPY;
                        n_rd    = r_wr + 1'b1;
                        n_state = ale_pkg::S_SCAN;
                    end
                    default: begin
                        n_done  = 1'b1;
                        n_state = ale_pkg::S_IDLE;
                    end
                endcase
            end

            // streaming walk: read ahead one word, act on the word that lands
            ale_pkg::S_SCAN: begin
                if (!r_pend && (r_rd >= r_count)) begin
                    n_done  = 1'b1;
                    n_state = ale_pkg::S_IDLE;
                    if (r_mode != ale_pkg::M_SEARCH) begin
                        n_count = r_wr;
                    end
                end else begin
                    if (r_pend) begin
                        unique case (r_mode)
                            ale_pkg::M_COPY: begin
                                o_wr_en   = 1'b1;
                                o_wr_addr = r_wr[AW-1:0];
                                n_wr      = r_wr + 1'b1;
                            end
                            ale_pkg::M_DROP: begin
                                if (match) begin
                                    n_removed = r_removed + 1'b1;
                                end else begin
                                    o_wr_en   = 1'b1;
                                    o_wr_addr = r_wr[AW-1:0];
                                    n_wr      = r_wr + 1'b1;
                                end
                            end
                            ale_pkg::M_SEARCH: begin
                                if (match) begin
                                    n_hit    = 1'b1;
                                    issue_ok = 1'b0;
                                    n_pend   = 1'b0;
                                    if (r_act == ale_pkg::ACT_REMOVE_FIRST) begin
                                        // close the gap behind the first match
                                        n_data = i_rd_data;
                                        n_mode = ale_pkg::M_COPY;
                                        n_rd   = r_paddr + 1'b1;
                                        n_wr   = r_paddr;
                                    end else begin
                                        n_done  = 1'b1;
                                        n_state = ale_pkg::S_IDLE;
                                    end
                                end
                            end
                            default: begin
                                n_state = ale_pkg::S_IDLE;
                            end
                        endcase
                    end
                    if (issue_ok) begin
                        if (r_rd < r_count) begin
                            o_rd_addr = r_rd[AW-1:0];
                            n_pend    = 1'b1;
                            n_paddr   = r_rd;
                            n_rd      = r_rd + 1'b1;
                        end else begin
                            n_pend = 1'b0;
                        end
                    end
                end
            end

            // low word in hand, read the high word
            ale_pkg::S_REV_B: begin
                n_hold    = i_rd_data;
                o_rd_addr = r_hi;
                n_state   = ale_pkg::S_REV_C;
            end

            // high word lands in the low slot, read the next low word
            ale_pkg::S_REV_C: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_lo;
                o_wr_data = i_rd_data;
                o_rd_addr = r_lo + 1'b1;
                n_state   = ale_pkg::S_REV_D;
            end

            // held low word into the high slot, read the next high word
            ale_pkg::S_REV_D: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_hi;
                o_wr_data = r_hold;
                n_hold    = i_rd_data;
                o_rd_addr = r_hi - 1'b1;
                n_lo      = r_lo + 1'b1;
                n_hi      = r_hi - 1'b1;
                if ((AW+1)'(r_lo) + (AW+1)'(2) < (AW+1)'(r_hi)) begin
                    n_state = ale_pkg::S_REV_C;
                end else begin
                    n_done  = 1'b1;
                    n_state = ale_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = ale_pkg::S_IDLE;
            end
        endcase
    end

    // result view
    assign o_busy               = (r_state != ale_pkg::S_IDLE);
    assign o_done               = r_done;
    assign o_word               = r_data;
    assign o_meta.hit           = r_hit;
    assign o_meta.removed_count = LEN_W'(r_removed);
    assign o_meta.length        = LEN_W'(r_count);
    assign o_meta.status        = r_status;

endmodule

// File: rtl/ale_checker.sv
`include "array_list_engine_macros.svh"

module ale_checker #(
    parameter int CAPACITY = ale_pkg::DEF_CAPACITY
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_done,
    input ale_pkg::t_rsp o_rsp
);

    localparam logic [ale_pkg::LEN_W-1:0] FULL_LEN = CAPACITY[ale_pkg::LEN_W-1:0];

    // a taken request either answers at once or keeps the engine busy
    `ALE_ASSERT_NEXT(a_req_progress, start && !busy, busy || o_done)

    // a result is only shown once the engine is free again
    `ALE_ASSERT_NOW(a_done_not_busy, o_done, !busy)

    // a refused append reports a full list
    `ALE_ASSERT_NOW(a_full_length, o_done && (o_rsp.status == ale_pkg::ST_FULL),
                    o_rsp.length == FULL_LEN)

    // an empty pop reports an empty list
    `ALE_ASSERT_NOW(a_empty_length, o_done && (o_rsp.status == ale_pkg::ST_EMPTY),
                    o_rsp.length == '0)

    // reset leaves the engine idle with no result pending
    `ALE_ASSERT_RESET(a_reset_idle, !busy && !o_done)

endmodule

bind array_list_engine ale_checker #(
    .CAPACITY (CAPACITY)
) u_ale_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);

// File: bench/array_list_engine_tb.sv
module array_list_engine_tb;

    import ale_pkg::*;

    localparam int CAPACITY    = DEF_CAPACITY;
    localparam int RANDOM_ITEMS = 1700;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_WAIT  = 300;

    // mirror of the list contents, predicting one result per request
    class list_mirror;
        logic [DATA_W-1:0] entries [CAPACITY];
        int unsigned       length;
        t_rsp              due_results [$];
        int unsigned       errors;

        function new();
            length = 0;
            errors = 0;
        endfunction

        // shift the words above the gap down by n places
        function void close_gap(int unsigned at, int unsigned n);
            int unsigned k;
            for (k = at; k + n < length; k++) begin
                entries[k] = entries[k + n];
            end
            length = length - n;
        endfunction

        function t_rsp apply_action(t_req r);
            t_rsp              res;
            int unsigned       k;
            int unsigned       w;
            logic [DATA_W-1:0] t;
            res = '0;
            case (r.action)
                ACT_APPEND: begin
                    if (length >= CAPACITY) begin
                        res.status = ST_FULL;
                    end else begin
                        entries[length] = r.value;
                        length++;
                    end
                end
                ACT_POP: begin
                    if (length == 0) begin
                        res.status = ST_EMPTY;
                    end else begin
                        length--;
                        res.data_out = entries[length];
                    end
                end
                ACT_GET, ACT_REPLACE, ACT_REMOVE_AT: begin
                    if (r.index >= length) begin
                        res.status = ST_RANGE;
                    end else begin
                        res.data_out = entries[r.index];
                        if (r.action == ACT_REPLACE) begin
                            entries[r.index] = r.value;
                        end else if (r.action == ACT_REMOVE_AT) begin
                            close_gap(r.index, 1);
                        end
                    end
                end
                ACT_REMOVE_RANGE: begin
                    if (int'(r.index) + int'(r.span) > int'(length)) begin
                        res.status = ST_RANGE;
                    end else begin
                        close_gap(r.index, r.span);
                    end
                end
                ACT_CONTAINS, ACT_REMOVE_FIRST: begin
                    for (k = 0; k < length; k++) begin
                        if (entries[k] == r.value) begin
                            res.hit = 1'b1;
                            if (r.action == ACT_REMOVE_FIRST) begin
                                res.data_out = entries[k];
                                close_gap(k, 1);
                            end
                            break;
                        end
                    end
                end
                ACT_REMOVE_ALL: begin
                    w = 0;
                    for (k = 0; k < length; k++) begin
                        if (entries[k] == r.value) begin
                            res.removed_count = res.removed_count + 1'b1;
                        end else begin
                            entries[w] = entries[k];
                            w++;
                        end
                    end
                    length = w;
                end
                ACT_REVERSE: begin
                    for (k = 0; k < length / 2; k++) begin
                        t = entries[length - 1 - k];
                        entries[length - 1 - k] = entries[k];
                        entries[k] = t;
                    end
                end
                default: begin
                end
            endcase
            res.length = LEN_W'(length);
            return res;
        endfunction

        function void note_request(t_req r);
            due_results.push_back(apply_action(r));
        endfunction

        // compare one result with the oldest prediction, field by field
        function void check_result(t_rsp got);
            t_rsp want;
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = due_results.pop_front();
            if (got.data_out !== want.data_out) begin
                $display("%0t: data_out expected %h actual %h", $time,
                         want.data_out, got.data_out);
                errors++;
            end
            if (got.hit !== want.hit) begin
                $display("%0t: hit expected %b actual %b", $time, want.hit, got.hit);
                errors++;
            end
            if (got.removed_count !== want.removed_count) begin
                $display("%0t: removed_count expected %0d actual %0d", $time,
                         want.removed_count, got.removed_count);
                errors++;
            end
            if (got.length !== want.length) begin
                $display("%0t: length expected %0d actual %0d", $time,
                         want.length, got.length);
                errors++;
            end
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time,
                         want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic  i_clk   = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start   = 1'b0;
    t_req  i_req   = '0;
    logic  busy;
    logic  o_done;
    t_rsp  o_rsp;

    list_mirror        mirror = new();
    logic [DATA_W-1:0] value_pool [4];
    bit                gaps_on = 1'b1;
    int unsigned       quiet_cycles = 0;

    array_list_engine uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    always #5 i_clk = ~i_clk;

    // results first, then the request taken at the same edge; watchdog on quiet cycles
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) begin
                mirror.check_result(o_rsp);
            end
            if (start && !busy) begin
                mirror.note_request(i_req);
            end
            if (o_done || (start && !busy)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // present one request, with an occasional idle cycle, and wait until it is taken
    task automatic send_request(t_req r);
        if (gaps_on && $urandom_range(99) < 11) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        @(negedge i_clk);
        start = 1'b1;
        i_req = r;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic send(logic [ACT_W-1:0] action, logic [IDX_W-1:0] index,
                        logic [SPAN_W-1:0] span, logic [DATA_W-1:0] value);
        t_req r;
        r.action = action;
        r.index  = index;
        r.span   = span;
        r.value  = value;
        send_request(r);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        if ($urandom_range(99) < 80) begin
            return value_pool[$urandom_range(3)];
        end
        return $urandom;
    endfunction

    // mostly well-formed requests against the current length, some noise
    function automatic t_req random_request(int unsigned len, int unsigned grow_pct);
        t_req        r;
        int unsigned room;
        r.value = pick_value();
        r.index = (len > 0) ? IDX_W'($urandom_range(len - 1)) : '0;
        if ($urandom_range(99) < 12) begin
            r.index = IDX_W'($urandom_range(255));
        end
        room = (len > r.index) ? len - r.index : 0;
        r.span = SPAN_W'($urandom_range(room < 8 ? room : 8));
        if ($urandom_range(99) < 10) begin
            r.span = SPAN_W'($urandom_range(room));
        end else if ($urandom_range(99) < 8) begin
            r.span = SPAN_W'($urandom_range(511));
        end
        if ($urandom_range(99) < grow_pct) begin
            r.action = ACT_APPEND;
        end else if ($urandom_range(99) < 5) begin
            r.action = ACT_W'($urandom);
            r.index  = IDX_W'($urandom);
            r.span   = SPAN_W'($urandom);
            r.value  = $urandom;
        end else begin
            case ($urandom_range(8))
                0: r.action = ACT_POP;
                1: r.action = ACT_GET;
                2: r.action = ACT_REPLACE;
                3: r.action = ACT_REMOVE_AT;
                4: r.action = ACT_REMOVE_RANGE;
                5: r.action = ACT_CONTAINS;
                6: r.action = ACT_REMOVE_FIRST;
                7: r.action = ACT_REMOVE_ALL;
                default: r.action = ACT_REVERSE;
            endcase
        end
        return r;
    endfunction

    // fill to capacity, exercise the full list, then empty it in one range
    task automatic fill_and_drain();
        while (mirror.length < CAPACITY) begin
            send(ACT_APPEND, '0, '0, pick_value());
        end
        send(ACT_APPEND, '0, '0, $urandom);
        send(ACT_APPEND, '0, '0, '1);
        send(ACT_GET, IDX_W'(CAPACITY - 1), '0, '0);
        send(ACT_REPLACE, IDX_W'(CAPACITY - 1), '0, $urandom);
        send(ACT_REVERSE, '0, '0, '0);
        send(ACT_CONTAINS, '0, '0, $urandom);
        send(ACT_REMOVE_AT, '0, '0, '0);
        send(ACT_APPEND, '0, '0, value_pool[0]);
        send(ACT_REMOVE_RANGE, 8'd1, SPAN_W'(CAPACITY), '0);
        send(ACT_REMOVE_RANGE, '0, SPAN_W'(CAPACITY), '0);
    endtask

    initial begin
        t_req        r;
        int unsigned random_sent;
        int unsigned phase;
        int unsigned grow_pct;
        random_sent = 0;
        phase = 0;

        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty list cases first
        send(ACT_POP, '0, '0, '0);
        send(ACT_GET, '0, '0, '0);
        send(ACT_REPLACE, '0, '0, 32'h1234_5678);
        send(ACT_REMOVE_AT, 8'hff, '0, '0);
        send(ACT_REMOVE_RANGE, '0, '0, '0);
        send(ACT_REMOVE_RANGE, '0, 9'd1, '0);
        send(ACT_CONTAINS, '0, '0, '0);
        send(ACT_REMOVE_FIRST, '0, '0, '1);
        send(ACT_REMOVE_ALL, '0, '0, '0);
        send(ACT_REVERSE, '0, '0, '0);
        send(ACT_REVERSE + 4'd6, 8'hff, 9'h1ff, '1);
        // directed: small list
        send(ACT_APPEND, '0, '0, '0);
        send(ACT_APPEND, '0, '0, '1);
        send(ACT_APPEND, '0, '0, 32'd5);
        send(ACT_APPEND, '0, '0, 32'd5);
        send(ACT_CONTAINS, '0, '0, 32'd5);
        send(ACT_REMOVE_FIRST, '0, '0, 32'd5);
        send(ACT_REMOVE_FIRST, '0, '0, 32'd7);
        send(ACT_GET, 8'd1, '0, '0);
        send(ACT_REPLACE, '0, '0, 32'haaaa_aaaa);
        send(ACT_REVERSE, '0, '0, '0);
        send(ACT_REMOVE_AT, '0, '0, '0);
        send(ACT_REMOVE_ALL, '0, '0, 32'd5);
        send(ACT_REMOVE_RANGE, '0, 9'd1, '0);
        send(ACT_POP, '0, '0, '0);

        // random phases, each with its own value pool and growth bias
        while (random_sent < RANDOM_ITEMS) begin
            value_pool[0] = $urandom;
            value_pool[1] = (phase % 3 == 0) ? '0 : $urandom;
            value_pool[2] = (phase % 3 == 0) ? '1 : $urandom;
            value_pool[3] = $urandom;
            gaps_on = (phase != 5) && (phase != 6);
            case (phase % 4)
                0: grow_pct = 55;
                1: grow_pct = 35;
                2: grow_pct = 20;
                default: grow_pct = 45;
            endcase
            if (phase % 6 == 2) begin
                fill_and_drain();
                random_sent += CAPACITY;
            end
            repeat (100) begin
                r = random_request(mirror.length, grow_pct);
                send_request(r);
                if (r.action <= ACT_REVERSE) begin
                    random_sent++;
                end
            end
            phase++;
        end

        @(negedge i_clk);
        start = 1'b0;

        // drain the outstanding predictions, then watch for stray results
        while (mirror.due_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mirror.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
